FILE: design/cmsm_pkg.sv
// shared types, function codes and fixed-point helpers for the scaled complex mac
`timescale 1ns / 1ps
`default_nettype none
package cmsm_pkg;

	typedef enum logic [2:0] {
		FUNC_LOAD_A  = 3'd0,
		FUNC_LOAD_B  = 3'd1,
		FUNC_LOAD_C  = 3'd2,
		FUNC_ADD     = 3'd3,
		FUNC_SUB     = 3'd4,
		FUNC_SET     = 3'd5
	} func_t;

	typedef struct packed {
		logic signed [31:0] re;
		logic signed [31:0] im;
	} cplx_t;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_SET = 2'd2
	} mode_t;

	localparam logic signed [31:0] WORD_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] WORD_MIN = 32'sh80000000;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v > 33'sh0_7fffffff) r = WORD_MAX;
		else if (v < -33'sh0_80000000) r = WORD_MIN;
		else r = v[31:0];
		return r;
	endfunction

	// fixed-point rescale of a full 64-bit product, floor shift then saturate
	function automatic logic signed [31:0] rescale(input logic signed [63:0] p,
			input logic [4:0] frac);
		logic signed [63:0] r;
		logic signed [31:0] o;
		r = p >>> frac;
		if (r > 64'sh7fffffff) o = WORD_MAX;
		else if (r < -64'sh80000000) o = WORD_MIN;
		else o = r[31:0];
		return o;
	endfunction

endpackage
`default_nettype wire

FILE: design/cmsm_cell.sv
// one mac cell: holds one c element, takes the a and b terms of each step
`timescale 1ns / 1ps
`default_nettype none
module cmsm_cell #(
	parameter int FRAC_BITS = 24
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cmsm_pkg::cplx_t      a_in,
	input  cmsm_pkg::cplx_t      b_in,
	input  wire                  step,
	input  wire                  first,
	input  cmsm_pkg::mode_t      mode,
	input  wire signed [31:0]    scale,
	input  wire                  load,
	input  cmsm_pkg::cplx_t      load_val,
	input  wire                  shift,
	input  cmsm_pkg::cplx_t      shift_in,
	output cmsm_pkg::cplx_t      c_out
);
	localparam logic [4:0] FB = 5'(FRAC_BITS);

	cmsm_pkg::cplx_t c_q;
	logic signed [63:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1;
	logic v_s1, v_s2, v_s3, f_s1, f_s2, f_s3;
	logic signed [31:0] tr_s2, ti_s2;
	logic signed [63:0] sr_s3, si_s3;
	logic signed [31:0] sr, si;
	logic signed [32:0] nr, ni;

	assign c_out = c_q;

	assign sr = cmsm_pkg::rescale(sr_s3, FB);
	assign si = cmsm_pkg::rescale(si_s3, FB);

	always_comb begin
		if (mode == cmsm_pkg::MODE_SUB) begin
			nr = 33'(c_q.re) - 33'(sr);
			ni = 33'(c_q.im) - 33'(si);
		end else begin
			nr = 33'(c_q.re) + 33'(sr);
			ni = 33'(c_q.im) + 33'(si);
		end
	end

	always_ff @(posedge clk) begin
		p_rr_s1 <= 64'(a_in.re) * 64'(b_in.re);
		p_ii_s1 <= 64'(a_in.im) * 64'(b_in.im);
		p_ir_s1 <= 64'(a_in.im) * 64'(b_in.re);
		p_ri_s1 <= 64'(a_in.re) * 64'(b_in.im);
		tr_s2 <= cmsm_pkg::sat33(33'(cmsm_pkg::rescale(p_rr_s1, FB))
			- 33'(cmsm_pkg::rescale(p_ii_s1, FB)));
		ti_s2 <= cmsm_pkg::sat33(33'(cmsm_pkg::rescale(p_ir_s1, FB))
			+ 33'(cmsm_pkg::rescale(p_ri_s1, FB)));
		sr_s3 <= 64'(scale) * 64'(tr_s2);
		si_s3 <= 64'(scale) * 64'(ti_s2);
		if (load) begin
			c_q <= load_val;
		end else if (shift) begin
			c_q <= shift_in;
		end else if (v_s3) begin
			if (mode == cmsm_pkg::MODE_SET && f_s3) begin
				c_q.re <= sr;
				c_q.im <= si;
			end else begin
				c_q.re <= cmsm_pkg::sat33(nr);
				c_q.im <= cmsm_pkg::sat33(ni);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			f_s1 <= 1'b0; f_s2 <= 1'b0; f_s3 <= 1'b0;
		end else begin
			v_s1 <= step; v_s2 <= v_s1; v_s3 <= v_s2;
			f_s1 <= first; f_s2 <= f_s1; f_s3 <= f_s2;
		end
	end
endmodule
`default_nettype wire

FILE: design/complex_matrix_scaled_mac.sv
// top level: scaled complex matrix multiply-accumulate over a chain of mac cells
//
// channel  dir  fields
// s_axis   in   tdata {scale, im_in, re_in, col, row}, tuser func
// m_axis   out  tdata {im_out, re_out, out_col, out_row}, tlast last
//
// loads are written as they are accepted. a compute item runs row by row: for
// row i, a row of DIM cells (one per column j, each holding column j of b and
// c) walks k over DIM steps with a registered read of a(i,k) and b(k,j) and a
// 3-stage multiply pipeline in each cell; each row result is written back to c
// and shifted out along the chain (stalled by m_axis_tready). no item is taken
// until all results of a compute are sent. reset clears control only; matrix
// contents are undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module complex_matrix_scaled_mac #(
	parameter int DIM       = 3,
	parameter int FRAC_BITS = 24
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [103:0] s_axis_tdata,  // row[2:0], col[5:3], re_in[37:6], im_in[69:38], scale[101:70]
	input  wire [2:0]   s_axis_tuser,  // func
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [71:0] m_axis_tdata,  // out_row[2:0], out_col[5:3], re_out[37:6], im_out[69:38]
	output logic        m_axis_tlast   // last
);
	localparam int NE = DIM * DIM;
	localparam int IW = (NE > 1) ? $clog2(NE) : 1;
	localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int CW = $clog2(2 * DIM + 8);

	typedef enum logic [1:0] {IDLE, RUN, DRAIN} state_t;

	cmsm_pkg::cplx_t a_mem [NE];

	state_t state_q;
	cmsm_pkg::mode_t mode_q;
	logic signed [31:0] scale_q;
	logic [DW-1:0] row_q, k_q, out_j_q;
	logic [CW-1:0] cyc_q;

	logic [2:0] in_row, in_col;
	logic [2:0] func;
	logic [IW-1:0] ld_idx;
	logic s_fire, m_fire;
	logic ld_ok;
	cmsm_pkg::cplx_t ld_val;

	cmsm_pkg::cplx_t a_rd_s1;
	cmsm_pkg::cplx_t c_cell [DIM];
	logic step, first, load_c, shift, c_wb;
	logic step_s1, first_s1;

	assign in_row = s_axis_tdata[2:0];
	assign in_col = s_axis_tdata[5:3];
	assign func = s_axis_tuser;
	assign ld_idx = IW'(32'(in_row) * DIM + 32'(in_col));
	assign s_axis_tready = (state_q == IDLE);
	assign s_fire = s_axis_tvalid && s_axis_tready;
	assign m_fire = m_axis_tvalid && m_axis_tready;
	assign ld_ok = s_fire && 32'(in_row) < DIM && 32'(in_col) < DIM;
	assign ld_val = {s_axis_tdata[37:6], s_axis_tdata[69:38]};

	always_ff @(posedge clk) begin
		if (ld_ok && func == cmsm_pkg::FUNC_LOAD_A) begin
			a_mem[ld_idx] <= ld_val;
		end
		a_rd_s1 <= a_mem[IW'(32'(row_q) * DIM + 32'(k_q))];
	end

	assign step = (state_q == RUN) && (32'(cyc_q) >= 1) && (32'(cyc_q) <= DIM);
	assign first = step && (k_q == '0);
	assign load_c = (state_q == RUN) && (cyc_q == '0);
	assign c_wb = (state_q == RUN) && (32'(cyc_q) == DIM + 5);
	assign shift = m_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_s1 <= 1'b0;
			first_s1 <= 1'b0;
		end else begin
			step_s1 <= step;
			first_s1 <= first;
		end
	end

	for (genvar j = 0; j < DIM; j++) begin : g_cell
		cmsm_pkg::cplx_t b_col [DIM];
		cmsm_pkg::cplx_t c_col [DIM];
		cmsm_pkg::cplx_t b_rd_s1;

		always_ff @(posedge clk) begin
			if (ld_ok && func == cmsm_pkg::FUNC_LOAD_B && 32'(in_col) == j) begin
				b_col[DW'(in_row)] <= ld_val;
			end
			if (ld_ok && func == cmsm_pkg::FUNC_LOAD_C && 32'(in_col) == j) begin
				c_col[DW'(in_row)] <= ld_val;
			end else if (c_wb) begin
				c_col[row_q] <= c_cell[j];
			end
			b_rd_s1 <= b_col[k_q];
		end

		cmsm_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.a_in(a_rd_s1),
			.b_in(b_rd_s1), .step(step_s1), .first(first_s1), .mode(mode_q),
			.scale(scale_q),
			.load(load_c), .load_val(c_col[row_q]),
			.shift(shift),
			.shift_in((j == DIM - 1) ? c_cell[j] : c_cell[(j + 1) % DIM]),
			.c_out(c_cell[j])
		);
	end

	assign m_axis_tvalid = (state_q == DRAIN);
	assign m_axis_tdata = {2'b00, c_cell[0].im, c_cell[0].re, 3'(out_j_q), 3'(row_q)};
	assign m_axis_tlast = (32'(row_q) == DIM - 1) && (32'(out_j_q) == DIM - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			mode_q <= cmsm_pkg::MODE_ADD;
			scale_q <= '0;
			row_q <= '0; k_q <= '0; out_j_q <= '0; cyc_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (s_fire && (func == cmsm_pkg::FUNC_ADD || func == cmsm_pkg::FUNC_SUB
							|| func == cmsm_pkg::FUNC_SET)) begin
						state_q <= RUN;
						mode_q <= (func == cmsm_pkg::FUNC_SUB) ? cmsm_pkg::MODE_SUB
							: (func == cmsm_pkg::FUNC_SET) ? cmsm_pkg::MODE_SET
							: cmsm_pkg::MODE_ADD;
						scale_q <= s_axis_tdata[101:70];
						row_q <= '0; k_q <= '0; cyc_q <= '0;
					end
				end
				RUN: begin
					cyc_q <= cyc_q + 1'b1;
					if (step) k_q <= (32'(k_q) == DIM - 1) ? '0 : k_q + 1'b1;
					if (32'(cyc_q) == DIM + 5) begin
						state_q <= DRAIN;
						out_j_q <= '0;
					end
				end
				DRAIN: begin
					if (m_fire) begin
						if (32'(out_j_q) == DIM - 1) begin
							out_j_q <= '0;
							cyc_q <= '0;
							if (32'(row_q) == DIM - 1) begin
								state_q <= IDLE;
							end else begin
								row_q <= row_q + 1'b1;
								state_q <= RUN;
							end
						end else begin
							out_j_q <= out_j_q + 1'b1;
						end
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != IDLE) |-> !s_axis_tready) else $error("accept while busy");
	a_out_only_drain: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (state_q == DRAIN)) else $error("output outside drain");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(m_fire && m_axis_tlast) |=> (state_q == IDLE)) else $error("last not final");
endmodule
`default_nettype wire
